>>> design/ichr_pkg.sv
// Shared types and constants for the interval cache hit-ratio monitor.
`timescale 1ns / 1ps

package ichr_pkg;

    localparam int RD_BITS      = 33;
    localparam int GAP_BITS     = 32;
    localparam int CACHE_BITS   = 32;
    localparam int WEIGHT_BITS  = 17;
    localparam int RATIO_BITS   = 17;
    localparam int OUT_CNT_BITS = 40;
    localparam int QFRAC_BITS   = 16;

    localparam logic [RATIO_BITS-1:0] Q16_ONE  = 17'h10000;
    localparam logic [RATIO_BITS-1:0] Q16_HALF = 17'h08000;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_CAPACITY     = 2'd0,
        REG_DECAY_MODE   = 2'd1,
        REG_DECAY_WEIGHT = 2'd2,
        REG_WINDOW_CHECK = 2'd3
    } cfg_reg_t;

    // Live configuration as seen by the front and back ends.
    typedef struct packed {
        logic [CACHE_BITS-1:0]  capacity;
        logic                   decay_mode;
        logic [WEIGHT_BITS-1:0] decay_weight;
        logic                   window_check;
    } cfg_t;

    // Fill status of the interval queue.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> design/ichr_front.sv
// Front end: classifies each request as hit or miss and keeps the run and interval counters.
`timescale 1ns / 1ps

module ichr_front
    import ichr_pkg::*;
#(
    parameter int COUNT_BITS = 40,
    localparam int EW = 4 * COUNT_BITS + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  beat_ok,
    input  logic [RD_BITS-1:0]    reuse_distance,
    input  logic [GAP_BITS-1:0]   previous_gap,
    input  logic                  run_start,
    input  logic                  interval_end,
    output logic                  push,
    output logic [EW-1:0]         push_data
);

    localparam int CW = (COUNT_BITS > GAP_BITS) ? COUNT_BITS : GAP_BITS;

    logic [COUNT_BITS-1:0] pos_reg, pos_next;
    logic [COUNT_BITS-1:0] ih_reg, ih_next;
    logic [COUNT_BITS-1:0] im_reg, im_next;
    logic [COUNT_BITS-1:0] rh_reg, rh_next;
    logic [COUNT_BITS-1:0] rm_reg, rm_next;
    logic                  first_reg, first_next;

    logic [COUNT_BITS-1:0] pos_base, ih_base, im_base, rh_base, rm_base;
    logic [COUNT_BITS-1:0] ih_cnt, im_cnt, rh_cnt, rm_cnt;
    logic                  first_base;
    logic                  size_hit, gap_outside, hit;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    // A run start clears everything before the flagged request is counted.
    always_comb begin
        pos_base   = run_start ? '0 : pos_reg;
        ih_base    = run_start ? '0 : ih_reg;
        im_base    = run_start ? '0 : im_reg;
        rh_base    = run_start ? '0 : rh_reg;
        rm_base    = run_start ? '0 : rm_reg;
        first_base = run_start | first_reg;
    end

    always_comb begin
        size_hit    = !reuse_distance[RD_BITS-1]
                      && (reuse_distance[CACHE_BITS-1:0] < cfg.capacity);
        gap_outside = !previous_gap[GAP_BITS-1]
                      && (CW'(previous_gap) > CW'(pos_base));
        hit         = size_hit && !(cfg.window_check && gap_outside);

        ih_cnt = hit ? sat_inc(ih_base) : ih_base;
        rh_cnt = hit ? sat_inc(rh_base) : rh_base;
        im_cnt = hit ? im_base : sat_inc(im_base);
        rm_cnt = hit ? rm_base : sat_inc(rm_base);
    end

    always_comb begin
        pos_next   = pos_reg;
        ih_next    = ih_reg;
        im_next    = im_reg;
        rh_next    = rh_reg;
        rm_next    = rm_reg;
        first_next = first_reg;
        if (beat_ok) begin
            pos_next = sat_inc(pos_base);
            rh_next  = rh_cnt;
            rm_next  = rm_cnt;
            if (interval_end) begin
                ih_next    = '0;
                im_next    = '0;
                first_next = 1'b0;
            end else begin
                ih_next    = ih_cnt;
                im_next    = im_cnt;
                first_next = first_base;
            end
        end
    end

    assign push      = beat_ok && interval_end;
    assign push_data = {first_base, rm_cnt, rh_cnt, im_cnt, ih_cnt};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            ih_reg    <= '0;
            im_reg    <= '0;
            rh_reg    <= '0;
            rm_reg    <= '0;
            first_reg <= 1'b1;
        end else begin
            pos_reg   <= pos_next;
            ih_reg    <= ih_next;
            im_reg    <= im_next;
            rh_reg    <= rh_next;
            rm_reg    <= rm_next;
            first_reg <= first_next;
        end
    end

endmodule

>>> design/ichr_queue.sv
// Two-entry queue of closed interval snapshots between the front and back ends.
`timescale 1ns / 1ps

module ichr_queue
    import ichr_pkg::*;
#(
    parameter int WIDTH = 161
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output q_status_t        status
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;

    always_comb begin
        status.full  = (count_reg == (PW+1)'(DEPTH));
        status.empty = (count_reg == '0);
        pop_data     = mem[rd_ptr_reg];
    end

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/ichr_back.sv
// Back end: restoring ratio divider, decay mix and the result register.
`timescale 1ns / 1ps

module ichr_back
    import ichr_pkg::*;
#(
    parameter int COUNT_BITS = 40,
    localparam int EW = 4 * COUNT_BITS + 1,
    localparam int OW = RATIO_BITS + 2 * OUT_CNT_BITS,
    localparam int OB = ((OW + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  cfg_t           cfg,
    input  q_status_t      q_status,
    input  logic [EW-1:0]  q_data,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [OB-1:0]  m_tdata
);

    localparam int TW = COUNT_BITS + 1;
    localparam int XW = (COUNT_BITS > OUT_CNT_BITS) ? COUNT_BITS : OUT_CNT_BITS;
    localparam int SW = $clog2(QFRAC_BITS);
    localparam int PBITS = 2 * RATIO_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_ROUND,
        ST_MULTIPLY,
        ST_MIX,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [COUNT_BITS-1:0]   h_reg, m_reg;
    logic [TW-1:0]           t_reg, r_reg;
    logic [QFRAC_BITS-1:0]   q_reg;
    logic [SW-1:0]           step_reg;
    logic                    first_reg;
    logic [RATIO_BITS-1:0]   ir_reg, ratio_reg, prev_reg;
    logic [PBITS-1:0]        p0_reg, p1_reg;
    logic [OUT_CNT_BITS-1:0] ih_out_reg, im_out_reg;
    logic                    m_valid_reg;
    logic [OB-1:0]           m_data_reg;

    logic [COUNT_BITS-1:0]   q_ih, q_im, q_rh, q_rm;
    logic                    q_first;
    logic [TW-1:0]           sum, t_val;
    logic                    zero_total, full_ratio;
    logic [TW:0]             r2, t2, diff;
    logic                    ge;
    logic [TW-1:0]           r_step;
    logic [RATIO_BITS-1:0]   round_q;
    logic [RATIO_BITS-1:0]   w, w_inv;
    logic [PBITS:0]          mix;
    logic [PBITS-QFRAC_BITS:0] mix_q;
    logic [RATIO_BITS-1:0]   mix_ratio;
    logic                    to_mix;
    logic                    out_free;

    function automatic logic [OUT_CNT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        sat_out = (x > XW'({OUT_CNT_BITS{1'b1}})) ? {OUT_CNT_BITS{1'b1}} : x[OUT_CNT_BITS-1:0];
    endfunction

    assign {q_first, q_rm, q_rh, q_im, q_ih} = q_data;
    assign pop      = (state_reg == ST_IDLE) && !q_status.empty;
    assign out_free = !m_valid_reg || m_tready;
    assign to_mix   = cfg.decay_mode && !first_reg;

    // Total with the saturation that only a full 64-bit count can need.
    always_comb begin
        sum   = TW'(h_reg) + TW'(m_reg);
        t_val = sum;
        if (COUNT_BITS == 64 && sum[COUNT_BITS]) begin
            t_val = {1'b0, {COUNT_BITS{1'b1}}};
        end
        zero_total = (h_reg == '0) && (m_reg == '0);
        full_ratio = (m_reg == '0) || (COUNT_BITS == 64 && (&h_reg));
    end

    // One restoring step: compare twice the remainder against the total.
    always_comb begin
        r2      = {r_reg, 1'b0};
        t2      = {1'b0, t_reg};
        ge      = (r2 >= t2);
        diff    = r2 - t2;
        r_step  = ge ? diff[TW-1:0] : r2[TW-1:0];
        round_q = {1'b0, q_reg} + RATIO_BITS'(ge);
    end

    always_comb begin
        w         = (cfg.decay_weight > Q16_ONE) ? Q16_ONE : cfg.decay_weight;
        w_inv     = Q16_ONE - w;
        mix       = (PBITS+1)'(p0_reg) + (PBITS+1)'(p1_reg) + (PBITS+1)'(Q16_HALF);
        mix_q     = mix[PBITS:QFRAC_BITS];
        mix_ratio = (mix_q > (PBITS-QFRAC_BITS+1)'(Q16_ONE)) ? Q16_ONE
                                                             : mix_q[RATIO_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            prev_reg    <= '0;
        end else begin
            if (m_tready && !(state_reg == ST_FINISH && out_free)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_status.empty) begin
                        h_reg      <= cfg.decay_mode ? q_ih : q_rh;
                        m_reg      <= cfg.decay_mode ? q_im : q_rm;
                        first_reg  <= q_first;
                        ih_out_reg <= sat_out(q_ih);
                        im_out_reg <= sat_out(q_im);
                        state_reg  <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    t_reg    <= t_val;
                    r_reg    <= TW'(h_reg);
                    q_reg    <= '0;
                    step_reg <= '0;
                    if (zero_total || full_ratio) begin
                        ir_reg    <= zero_total ? '0 : Q16_ONE;
                        ratio_reg <= zero_total ? '0 : Q16_ONE;
                        state_reg <= to_mix ? ST_MULTIPLY : ST_FINISH;
                    end else begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    r_reg    <= r_step;
                    q_reg    <= {q_reg[QFRAC_BITS-2:0], ge};
                    step_reg <= step_reg + SW'(1);
                    if (step_reg == SW'(QFRAC_BITS - 1)) begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    ir_reg    <= round_q;
                    ratio_reg <= round_q;
                    state_reg <= to_mix ? ST_MULTIPLY : ST_FINISH;
                end
                ST_MULTIPLY: begin
                    p0_reg    <= PBITS'(prev_reg) * PBITS'(w);
                    p1_reg    <= PBITS'(ir_reg) * PBITS'(w_inv);
                    state_reg <= ST_MIX;
                end
                ST_MIX: begin
                    ratio_reg <= mix_ratio;
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= OB'({im_out_reg, ih_out_reg, ratio_reg});
                        prev_reg    <= ratio_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> design/interval_cache_hit_ratio.sv
// Top level of the interval cache hit-ratio monitor: configuration registers and wiring.
`timescale 1ns / 1ps

// A closing beat queues a snapshot; the back end pops it, divides, rounds, applies any decay
// mix and loads m_tdata; an empty or all-hit total skips the division. Throughput: one
// request beat per cycle; closed intervals wait in a two-entry queue and the back end
// handles one at a time, mostly in its one-bit-per-cycle divider. s_tready falls only
// while that queue is full. Reset (aresetn low, synchronous) clears all counters, the
// previous ratio, the queue and the output, and sets registers to defaults.

module interval_cache_hit_ratio
    import ichr_pkg::*;
#(
    parameter int COUNT_BITS = 40
) (
    input  logic         aclk,
    input  logic         aresetn,

    // Configuration write port, no read-back.
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,

    // Request beats.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,  // [32:0] reuse_distance, [64:33] previous_gap, rest zero
    input  logic         s_tuser,  // [0] run_start
    input  logic         s_tlast,  // interval_end

    // Result beats.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata   // [16:0] hit_ratio, [56:17] interval_hits,
                                   // [96:57] interval_misses, rest zero
);

    localparam int EW = 4 * COUNT_BITS + 1;

    // The four registers of the configuration port. Both ends read them directly, so
    // the user must change them only while the block is idle; the block does not enforce it.
    logic [CACHE_BITS-1:0]  capacity_reg;
    logic                   decay_mode_reg;
    logic [WEIGHT_BITS-1:0] decay_weight_reg;
    logic                   window_check_reg;
    cfg_t                   cfg;

    logic                   beat_ok;
    logic                   push, pop;
    logic [EW-1:0]          push_data, pop_data;
    q_status_t              q_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg     <= '0;
            decay_mode_reg   <= 1'b0;
            decay_weight_reg <= '0;
            window_check_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_CAPACITY:     capacity_reg     <= cfg_wdata[CACHE_BITS-1:0];
                REG_DECAY_MODE:   decay_mode_reg   <= cfg_wdata[0];
                REG_DECAY_WEIGHT: decay_weight_reg <= cfg_wdata[WEIGHT_BITS-1:0];
                REG_WINDOW_CHECK: window_check_reg <= cfg_wdata[0];
            endcase
        end
    end

    assign cfg.capacity     = capacity_reg;
    assign cfg.decay_mode   = decay_mode_reg;
    assign cfg.decay_weight = decay_weight_reg;
    assign cfg.window_check = window_check_reg;

    // The front end never waits on the divider as long as the queue has room.
    assign s_tready = !q_status.full;
    assign beat_ok  = s_tvalid && s_tready;

    ichr_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .beat_ok        (beat_ok),
        .reuse_distance (s_tdata[RD_BITS-1:0]),
        .previous_gap   (s_tdata[RD_BITS+GAP_BITS-1:RD_BITS]),
        .run_start      (s_tuser),
        .interval_end   (s_tlast),
        .push           (push),
        .push_data      (push_data)
    );

    ichr_queue #(
        .WIDTH (EW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // The back end holds the previous ratio and owns the output register, so a
    // finished result can wait for m_tready while the front keeps taking requests.
    ichr_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_status (q_status),
        .q_data   (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> design/ichr_checker.sv
// Port-level checks on the result channel of the hit-ratio monitor, bound to the top level.
`timescale 1ns / 1ps

module ichr_checker
    import ichr_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    // A result waiting for the sink stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat withdrawn while stalled");

    // The ratio never exceeds one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[RATIO_BITS-1:0] <= Q16_ONE))
        else $error("hit ratio above 1.0");

    // The bits above the miss count are always zero in a result beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[103:97] == '0))
        else $error("padding bits of result beat not zero");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind interval_cache_hit_ratio ichr_checker u_ichr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
